@@ hw/rtl/crs_pkg.sv @@
// crs_pkg: shared types, constants and the cosine table builder for the
// chirp reference subtractor. No dependencies; every other file imports it.

package crs_pkg;

  localparam int LINE_LEN        = 16384;
  localparam int MAX_PULSE       = 2048;
  localparam int COS_TABLE_DEPTH = 1024;

  localparam int SAMPLE_W   = 16;
  localparam int WSTART_W   = 14;
  localparam int PLEN_W     = 11;
  localparam int SCALE_W    = 16;
  localparam int PHASE_W    = 32;
  localparam int CLAMP_W    = 15;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam int POS_W      = $clog2(LINE_LEN);
  localparam int CMP_W      = ((POS_W > WSTART_W) ? POS_W : WSTART_W) + 1;
  localparam int COS_ADDR_W = $clog2(COS_TABLE_DEPTH);
  localparam int COS_W      = 15;
  localparam int COS_ONE    = 16384;
  localparam int PROD_W     = SCALE_W + COS_W;
  localparam int RND_SHIFT  = 14;
  localparam int TERM_W     = SCALE_W + 1;
  localparam int DIFF_W     = TERM_W + 1;

  localparam longint TAYLOR_Q30 [6] = '{
    64'd1073741824, 64'd1324675879, 64'd272375560,
    64'd22401992,   64'd987048,     64'd27061
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_START = 3'd0,
    CFG_PULSE_LEN    = 3'd1,
    CFG_SCALE        = 3'd2,
    CFG_START_PHASE  = 3'd3,
    CFG_START_FREQ   = 3'd4,
    CFG_CHIRP_RATE   = 3'd5,
    CFG_CLAMP_LIMIT  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [WSTART_W-1:0] window_start;
    logic [PLEN_W-1:0]   pulse_len;
    logic [SCALE_W-1:0]  scale;
    logic [PHASE_W-1:0]  start_phase;
    logic [PHASE_W-1:0]  start_freq;
    logic [PHASE_W-1:0]  chirp_rate;
    logic [CLAMP_W-1:0]  clamp_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       line_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_of_line;
  } out_item_t;

  // stage load enables from the handshake control
  typedef struct packed {
    logic accept;
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       in_win;
    logic                       neg;
    logic [COS_ADDR_W-1:0]      addr;
  } s1_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       in_win;
    logic                       neg;
    logic [COS_W-1:0]           cos_mag;
  } s2_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       in_win;
    logic signed [TERM_W-1:0]   term;
  } s3_t;

  typedef logic [COS_TABLE_DEPTH-1:0][COS_W-1:0] cos_rom_t;

  // quarter-wave cosine sample at bin center, unsigned Q1.14, Taylor series via Horner
  function automatic logic [COS_W-1:0] cos_rom_entry(input int unsigned idx);
    logic [63:0] s;
    logic [63:0] s2;
    logic [63:0] prod;
    longint      p;
    int          k;
    s  = (64'(2 * idx + 1) << 15) / COS_TABLE_DEPTH;
    s2 = (s * s) >> 2;
    p  = TAYLOR_Q30[5];
    for (k = 4; k >= 0; k--) begin
      prod = 64'(p) * s2;
      p    = TAYLOR_Q30[k] - longint'(prod >> 30);
      if (p < 0) begin
        p = 0;
      end
    end
    p = (p + 32768) >>> 16;
    if (p > COS_ONE) begin
      p = COS_ONE;
    end
    return COS_W'(p);
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      rom[i] = cos_rom_entry(i);
    end
    return rom;
  endfunction

endpackage

@@ hw/rtl/crs_phase_gen.sv @@
// crs_phase_gen: line position counter, window decode and second-order
// chirp phase accumulator; first pipeline register. Uses crs_pkg.

module crs_phase_gen import crs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t ctl,
  input  cfg_regs_t cfg,
  input  in_item_t  item,
  output s1_t       s1_r
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PHASE_W-1:0] inc_r, inc_nxt;

  logic [CMP_W-1:0]      pos_ext, ws_ext, len_eff, win_end;
  logic                  in_win, at_start;
  logic [PHASE_W-1:0]    ph_sel, inc_sel;
  logic [1:0]            quad;
  logic [COS_ADDR_W-1:0] idx;
  s1_t                   s1_nxt;

  always_comb begin
    pos_ext = CMP_W'(pos_r);
    ws_ext  = CMP_W'(cfg.window_start);
    len_eff = (CMP_W'(cfg.pulse_len) > CMP_W'(MAX_PULSE)) ? CMP_W'(MAX_PULSE)
                                                          : CMP_W'(cfg.pulse_len);
    win_end  = ws_ext + len_eff;
    in_win   = (pos_ext >= ws_ext) && (pos_ext < win_end);
    at_start = (pos_ext == ws_ext);

    // accumulator restarts at the first sample of the window
    ph_sel  = at_start ? cfg.start_phase : phase_r;
    inc_sel = at_start ? cfg.start_freq  : inc_r;

    phase_nxt = phase_r;
    inc_nxt   = inc_r;
    if (in_win) begin
      phase_nxt = ph_sel + inc_sel;
      inc_nxt   = inc_sel + cfg.chirp_rate;
    end

    if (item.line_end || (pos_r == POS_W'(LINE_LEN - 1))) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end

    // odd quadrants read the mirrored entry, quadrants 1 and 2 are negative
    quad = ph_sel[PHASE_W-1 -: 2];
    idx  = ph_sel[PHASE_W-3 -: COS_ADDR_W];

    s1_nxt.sample = item.sample_in;
    s1_nxt.last   = item.line_end;
    s1_nxt.in_win = in_win;
    s1_nxt.neg    = quad[1] ^ quad[0];
    s1_nxt.addr   = quad[0] ? (COS_ADDR_W'(COS_TABLE_DEPTH - 1) - idx) : idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= '0;
      inc_r   <= '0;
    end else if (ctl.accept) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      inc_r   <= inc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

@@ hw/rtl/crs_cos_lut.sv @@
// crs_cos_lut: quarter-wave cosine ROM with registered read, carries the
// sample sideband alongside. Uses crs_pkg (table builder).

module crs_cos_lut import crs_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  s1_t       s1,
  output s2_t       s2_r
);

  localparam cos_rom_t COS_ROM = build_cos_rom();

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      s2_r.sample  <= s1.sample;
      s2_r.last    <= s1.last;
      s2_r.in_win  <= s1.in_win;
      s2_r.neg     <= s1.neg;
      s2_r.cos_mag <= COS_ROM[s1.addr];
    end
  end

endmodule

@@ hw/rtl/crs_cancel.sv @@
// crs_cancel: scales the chirp sample, rounds to Q8.8, subtracts it and
// clamps; output register. Uses crs_pkg.

module crs_cancel import crs_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  cfg_regs_t cfg,
  input  s2_t       s2,
  output out_item_t out_r,
  output logic      out_win_r
);

  logic [PROD_W-1:0]        prod, prod_rnd;
  logic [SCALE_W-1:0]       mag;
  s3_t                      s3_r, s3_nxt;
  logic signed [DIFF_W-1:0] diff, lim_pos, lim_neg, clamped;
  out_item_t                out_nxt;

  always_comb begin
    prod     = PROD_W'(cfg.scale) * PROD_W'(s2.cos_mag);
    // round half away from zero on the magnitude
    prod_rnd = prod + PROD_W'(1 << (RND_SHIFT - 1));
    mag      = SCALE_W'(prod_rnd >> RND_SHIFT);

    s3_nxt.sample = s2.sample;
    s3_nxt.last   = s2.last;
    s3_nxt.in_win = s2.in_win;
    s3_nxt.term   = s2.neg ? -$signed(TERM_W'(mag)) : $signed(TERM_W'(mag));
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      s3_r <= s3_nxt;
    end
  end

  always_comb begin
    diff    = DIFF_W'(s3_r.sample) - DIFF_W'(s3_r.term);
    lim_pos = $signed(DIFF_W'(cfg.clamp_limit));
    lim_neg = -lim_pos;
    if (diff > lim_pos) begin
      clamped = lim_pos;
    end else if (diff < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = diff;
    end
    out_nxt.sample_out   = s3_r.in_win ? SAMPLE_W'(clamped) : s3_r.sample;
    out_nxt.last_of_line = s3_r.last;
  end

  always_ff @(posedge clk) begin
    if (ctl.en4) begin
      out_r     <= out_nxt;
      out_win_r <= s3_r.in_win;
    end
  end

endmodule

@@ hw/rtl/chirp_reference_subtractor.sv @@
// chirp_reference_subtractor: top level with configuration registers and
// pipeline handshake control. Uses crs_pkg, crs_phase_gen, crs_cos_lut, crs_cancel.
//
// Usage:
//   in_valid/in_ready/in_data carry one Q8.8 line sample and its line_end
//   flag per transaction; out_valid/out_ready/out_data return the sample
//   with the scaled chirp removed inside the window, clamped to the limit,
//   or unchanged outside it, with last_of_line copied from line_end.
//   cfg_we/cfg_index/cfg_wdata write one register per cycle; write only
//   while no transaction is in flight.
//   Throughput is one sample per cycle while out_ready holds: the phase
//   accumulator update is two 32-bit adds, the cosine ROM read is registered
//   and the multiply has its own stage.
//   Each of the four stages has its own valid bit, so a stalled receiver
//   only holds stages that are full; input keeps flowing into empty ones
//   and in_ready drops once all four hold a sample.
//   Reset (rst_n low, synchronous) empties the pipeline, zeroes the line
//   position and the chirp accumulator and restores the default registers.

module chirp_reference_subtractor import crs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t cfg_r;
  pipe_ctl_t ctl;
  s1_t       s1;
  s2_t       s2;
  logic      out_win;

  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic rdy1, rdy2, rdy3, rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_start <= '0;
      cfg_r.pulse_len    <= PLEN_W'(1538);
      cfg_r.scale        <= SCALE_W'(256);
      cfg_r.start_phase  <= '0;
      cfg_r.start_freq   <= '0;
      cfg_r.chirp_rate   <= '0;
      cfg_r.clamp_limit  <= CLAMP_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_START: cfg_r.window_start <= cfg_wdata[WSTART_W-1:0];
        CFG_PULSE_LEN:    cfg_r.pulse_len    <= cfg_wdata[PLEN_W-1:0];
        CFG_SCALE:        cfg_r.scale        <= cfg_wdata[SCALE_W-1:0];
        CFG_START_PHASE:  cfg_r.start_phase  <= cfg_wdata[PHASE_W-1:0];
        CFG_START_FREQ:   cfg_r.start_freq   <= cfg_wdata[PHASE_W-1:0];
        CFG_CHIRP_RATE:   cfg_r.chirp_rate   <= cfg_wdata[PHASE_W-1:0];
        CFG_CLAMP_LIMIT:  cfg_r.clamp_limit  <= cfg_wdata[CLAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage can load when it is empty or its content moves on
  always_comb begin
    rdy4 = !out_vld_r || out_ready;
    rdy3 = !s3_vld_r || rdy4;
    rdy2 = !s2_vld_r || rdy3;
    rdy1 = !s1_vld_r || rdy2;

    ctl.accept = in_valid && rdy1;
    ctl.en1    = rdy1;
    ctl.en2    = rdy2;
    ctl.en3    = rdy3;
    ctl.en4    = rdy4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy1) s1_vld_r  <= in_valid;
      if (rdy2) s2_vld_r  <= s1_vld_r;
      if (rdy3) s3_vld_r  <= s2_vld_r;
      if (rdy4) out_vld_r <= s3_vld_r;
    end
  end

  crs_phase_gen u_phase_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cfg   (cfg_r),
    .item  (in_data),
    .s1_r  (s1)
  );

  crs_cos_lut u_cos_lut (
    .clk  (clk),
    .ctl  (ctl),
    .s1   (s1),
    .s2_r (s2)
  );

  crs_cancel u_cancel (
    .clk       (clk),
    .ctl       (ctl),
    .cfg       (cfg_r),
    .s2        (s2),
    .out_r     (out_data),
    .out_win_r (out_win)
  );

  assign in_ready  = rdy1;
  assign out_valid = out_vld_r;

`ifndef SYNTHESIS
  // an empty output stage means nothing upstream can block input
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with empty output stage");

  // input is held back only when every stage holds a transaction
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> ($countones({s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r}) == 4)
                  && !out_ready)
    else $error("input stalled with room in the pipeline");

  // in-window results never exceed the clamp magnitude
  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_win) |->
      ($signed(DIFF_W'(out_data.sample_out)) <= $signed(DIFF_W'(cfg_r.clamp_limit)))
      && ($signed(DIFF_W'(out_data.sample_out))
          >= -$signed(DIFF_W'(cfg_r.clamp_limit))))
    else $error("in-window result outside clamp limit");

  // a transaction moves into the output stage only from the stage before it
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !$past(out_vld_r)) |-> $past(s3_vld_r))
    else $error("output stage filled without source");
`endif

endmodule
